[sv/bdc_pkg.sv]
`default_nettype none

package bdc_pkg;

    localparam logic [7:0]  BRAILLE_ROW = 8'h28;
    localparam logic [15:0] UNIT_ZERO   = 16'h0030;
    localparam logic [15:0] UNIT_ONE    = 16'h0031;
    localparam logic [15:0] UNIT_EIGHT  = 16'h0038;
    localparam logic [15:0] UNIT_DASH   = 16'h002D;

    // Result queue depth; one item can add two results.
    localparam int BDC_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] dot_pattern;
        logic       cell_present;
        logic       line_done;
    } t_result;

    // Results produced by one accepted item.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

`default_nettype wire

[sv/bdc_if.sv]
`default_nettype none

interface bdc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        line_end;

    modport source (output valid, output code_unit, output line_end, input ready);
    modport sink   (input valid, input code_unit, input line_end, output ready);
endinterface

interface bdc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] dot_pattern;
    logic       cell_present;
    logic       line_done;

    modport source (output valid, output dot_pattern, output cell_present,
                    output line_done, input ready);
    modport sink   (input valid, input dot_pattern, input cell_present,
                    input line_done, output ready);
endinterface

`default_nettype wire

[sv/braille_dot_digits_to_cells_top.sv]
`default_nettype none

// An item's first result is offered the cycle after it is accepted, if the queue was empty.
// Throughput: one item per cycle while the queue has room; results leave one per
// cycle when ready, and a braille unit flushing a pending cell makes two results.
// The four-entry result queue accepts a new item while it has room for two results.
// Reset (synchronous, active low) clears the pending cell, the halt flag and the queue.
module braille_dot_digits_to_cells_top
    import bdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = BDC_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bdc_in_if.sink     i_in,
    bdc_out_if.source  o_out
);

    logic    accept;
    logic    has_room;
    t_push   push;
    t_result head;

    assign i_in.ready = has_room;
    assign accept     = i_in.valid && has_room;

    bdc_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_unit (i_in.code_unit),
        .i_line_end  (i_in.line_end),
        .o_push      (push)
    );

    bdc_result_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_en  (accept),
        .i_push     (push),
        .o_has_room (has_room),
        .o_valid    (o_out.valid),
        .i_pop      (o_out.ready),
        .o_result   (head)
    );

    assign o_out.dot_pattern  = head.dot_pattern;
    assign o_out.cell_present = head.cell_present;
    assign o_out.line_done    = head.line_done;

endmodule

`default_nettype wire

[sv/bdc_decode.sv]
`default_nettype none

module bdc_decode
    import bdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_line_end,
    output t_push            o_push
);

    logic [7:0] r_pend_dots, n_pend_dots;
    logic       r_pend_act, n_pend_act;
    logic       r_halted, n_halted;

    logic       is_braille, is_zero, is_digit, is_dash;
    logic [2:0] dot_idx;
    t_result    cell_pend, cell_unit, cell_bare;

    assign is_braille = (i_code_unit[15:8] == BRAILLE_ROW);
    assign is_zero    = (i_code_unit == UNIT_ZERO);
    assign is_digit   = (i_code_unit >= UNIT_ONE) && (i_code_unit <= UNIT_EIGHT);
    assign is_dash    = (i_code_unit == UNIT_DASH);
    // Digits 1..8 map to dot bits 0..7; the low three bits wrap for 8.
    assign dot_idx    = i_code_unit[2:0] - 3'd1;

    always_comb begin
        cell_pend = '{dot_pattern: r_pend_dots, cell_present: 1'b1, line_done: 1'b0};
        cell_unit = '{dot_pattern: i_code_unit[7:0], cell_present: 1'b1, line_done: 1'b0};
        cell_bare = '{dot_pattern: 8'h00, cell_present: 1'b0, line_done: 1'b0};

        n_pend_dots = r_pend_dots;
        n_pend_act  = r_pend_act;
        n_halted    = r_halted;
        o_push      = '{count: 2'd0, first: cell_bare, second: cell_bare};

        if (!r_halted) begin
            if (is_braille) begin
                if (r_pend_act) begin
                    o_push.first  = cell_pend;
                    o_push.second = cell_unit;
                    o_push.count  = 2'd2;
                end else begin
                    o_push.first = cell_unit;
                    o_push.count = 2'd1;
                end
                n_pend_dots = 8'h00;
                n_pend_act  = 1'b0;
            end else if (is_zero) begin
                n_pend_dots = 8'h00;
                n_pend_act  = 1'b1;
            end else if (is_digit) begin
                n_pend_dots = r_pend_dots | (8'h01 << dot_idx);
                n_pend_act  = 1'b1;
            end else begin
                // A dash flushes; anything else flushes and stops the line.
                if (r_pend_act) begin
                    o_push.first = cell_pend;
                    o_push.count = 2'd1;
                end
                n_pend_dots = 8'h00;
                n_pend_act  = 1'b0;
                n_halted    = !is_dash;
            end
        end

        if (i_line_end) begin
            // Only a digit or zero leaves a cell pending, so no results exist yet.
            if (n_pend_act) begin
                o_push.first = '{dot_pattern: n_pend_dots, cell_present: 1'b1,
                                 line_done: 1'b0};
                o_push.count = 2'd1;
            end else if (o_push.count == 2'd0) begin
                o_push.count = 2'd1;
            end
            if (o_push.count == 2'd2) begin
                o_push.second.line_done = 1'b1;
            end else begin
                o_push.first.line_done = 1'b1;
            end
            n_pend_dots = 8'h00;
            n_pend_act  = 1'b0;
            n_halted    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_dots <= 8'h00;
            r_pend_act  <= 1'b0;
            r_halted    <= 1'b0;
        end else if (i_accept) begin
            r_pend_dots <= n_pend_dots;
            r_pend_act  <= n_pend_act;
            r_halted    <= n_halted;
        end
    end

    a_line_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_line_end |-> o_push.count != 2'd0)
        else $error("line end produced no result");

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_line_end |=> !r_halted && !r_pend_act)
        else $error("state not cleared after line end");

    a_pair_both_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count == 2'd2 |-> o_push.first.cell_present && o_push.second.cell_present
            && !o_push.first.line_done)
        else $error("malformed result pair");

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted && !i_line_end |-> o_push.count == 2'd0)
        else $error("halted line produced a result");

endmodule

`default_nettype wire

[sv/bdc_result_queue.sv]
`default_nettype none

module bdc_result_queue
    import bdc_pkg::*;
#(
    parameter int DEPTH = BDC_QUEUE_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_en,
    input  wire t_push i_push,
    output logic       o_has_room,
    output logic       o_valid,
    input  wire logic  i_pop,
    output t_result    o_result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [1:0]         push_n;
    logic               pop_en;

    assign push_n      = i_push_en ? i_push.count : 2'd0;
    assign pop_en      = i_pop && (r_count != '0);
    assign wr_ptr_next = r_wr_ptr + PTR_W'(1);
    // Room for a worst-case item of two results.
    assign o_has_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_valid     = (r_count != '0);
    assign o_result    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr + PTR_W'(push_n);
        n_rd_ptr = pop_en ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(push_n) - CNT_W'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_n != 2'd0 |-> o_has_room)
        else $error("push without room");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != CNT_W'(DEPTH) |-> PTR_W'(r_wr_ptr - r_rd_ptr) == PTR_W'(r_count))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[test/testbench.sv]
`default_nettype none

module testbench
    import bdc_pkg::*;
();

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 250000;
    localparam int HOLD_CYCLES     = 300;
    localparam int UNITS_PER_PHASE = 470;
    localparam int TAIL_CYCLES     = 8;

    // Tracks the pending cell of the line and the cells the block still owes.
    class cell_scoreboard;
        logic [7:0] pending_dots;
        bit         pending_active;
        bit         halted;
        t_result    cells_due[$];
        int         mismatches;
        int         cells_checked;
        int         lines_closed;
        int         units_used;

        function new();
            pending_dots   = '0;
            pending_active = 1'b0;
            halted         = 1'b0;
            mismatches     = 0;
            cells_checked  = 0;
            lines_closed   = 0;
            units_used     = 0;
        endfunction

        function void note_unit(logic [15:0] unit, logic last);
            t_result step_out[2];
            int      n;
            n = 0;
            units_used++;
            if (!halted) begin
                if (unit[15:8] == BRAILLE_ROW) begin
                    if (pending_active) begin
                        step_out[n] = '{pending_dots, 1'b1, 1'b0};
                        n++;
                    end
                    pending_dots   = '0;
                    pending_active = 1'b0;
                    step_out[n] = '{unit[7:0], 1'b1, 1'b0};
                    n++;
                end else if (unit == UNIT_ZERO) begin
                    pending_dots   = '0;
                    pending_active = 1'b1;
                end else if (unit >= UNIT_ONE && unit <= UNIT_EIGHT) begin
                    pending_dots   = pending_dots | (8'h01 << (unit - UNIT_ONE));
                    pending_active = 1'b1;
                end else begin
                    // A dash only flushes; anything else also stops the line.
                    if (pending_active) begin
                        step_out[n] = '{pending_dots, 1'b1, 1'b0};
                        n++;
                    end
                    pending_dots   = '0;
                    pending_active = 1'b0;
                    if (unit != UNIT_DASH) begin
                        halted = 1'b1;
                    end
                end
            end
            if (last) begin
                if (pending_active) begin
                    step_out[n] = '{pending_dots, 1'b1, 1'b0};
                    n++;
                end
                if (n == 0) begin
                    step_out[0] = '{8'h00, 1'b0, 1'b0};
                    n = 1;
                end
                step_out[n-1].line_done = 1'b1;
                pending_dots   = '0;
                pending_active = 1'b0;
                halted         = 1'b0;
                lines_closed++;
            end
            for (int k = 0; k < n; k++) begin
                cells_due.push_back(step_out[k]);
            end
        endfunction

        function void check_cell(t_result got);
            t_result want;
            if (cells_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result dots=%02h present=%0b done=%0b",
                         $time, got.dot_pattern, got.cell_present, got.line_done);
            end else begin
                want = cells_due.pop_front();
                cells_checked++;
                if (got.dot_pattern != want.dot_pattern ||
                    got.cell_present != want.cell_present ||
                    got.line_done != want.line_done) begin
                    mismatches++;
                    $display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             $time, want.dot_pattern, want.cell_present, want.line_done,
                             got.dot_pattern, got.cell_present, got.line_done);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bdc_in_if  in_if();
    bdc_out_if out_if();

    braille_dot_digits_to_cells_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    cell_scoreboard sb;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;
    int      hold_requests = 0;
    int      hold_served   = 0;
    int      hold_left     = 0;
    int      cycle_count   = 0;
    t_result seen;

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("braille_dot_digits_to_cells_top verification failed");
            $finish;
        end
    end

    // Output side: checks each accepted result and decides ready for the next edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                seen.dot_pattern  = out_if.dot_pattern;
                seen.cell_present = out_if.cell_present;
                seen.line_done    = out_if.line_done;
                sb.check_cell(seen);
            end
            if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_unit(input logic [15:0] unit, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.code_unit <= unit;
        in_if.line_end  <= last;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        sb.note_unit(unit, last);
    endtask

    // Always drops valid and waits on the clock before checking, so valid never toggles twice in a step.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.cells_due.size() != 0);
    endtask

    function automatic logic [15:0] random_unit();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            return UNIT_ZERO + 16'($urandom_range(8));
        end else if (pick < 60) begin
            return UNIT_DASH;
        end else if (pick < 80) begin
            return {BRAILLE_ROW, 8'($urandom)};
        end else if (pick < 82) begin
            case ($urandom_range(7))
                0:       return 16'h27FF;
                1:       return 16'h2900;
                2:       return 16'h002F;
                3:       return 16'h0039;
                4:       return 16'h0000;
                5:       return 16'hFFFF;
                6:       return 16'hD800;
                default: return 16'hDFFF;
            endcase
        end else if (pick < 84) begin
            return 16'($urandom);
        end else begin
            return UNIT_ONE + 16'($urandom_range(7));
        end
    endfunction

    task automatic send_random_line();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            send_unit(random_unit(), i == len - 1);
        end
    endtask

    task automatic run_lines(input int target);
        int start;
        start = sb.units_used;
        while (sb.units_used - start < target) begin
            send_random_line();
        end
    endtask

    initial begin
        in_if.valid     = 1'b0;
        in_if.code_unit = '0;
        in_if.line_end  = 1'b0;
        out_if.ready    = 1'b0;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed lines: empty cell, digit accumulation, a zero that drops dots,
        // braille range limits, halting units and bare end marks.
        send_unit(UNIT_ZERO, 1'b1);
        send_unit(UNIT_ONE, 1'b0);
        send_unit(UNIT_EIGHT, 1'b0);
        send_unit(UNIT_ONE + 16'd1, 1'b0);
        send_unit(UNIT_DASH, 1'b0);
        send_unit(UNIT_ONE + 16'd4, 1'b0);
        send_unit(UNIT_ZERO, 1'b0);
        send_unit(UNIT_ONE + 16'd2, 1'b0);
        send_unit(16'h28FF, 1'b0);
        send_unit(16'h2800, 1'b1);
        send_unit(UNIT_DASH, 1'b1);
        send_unit(UNIT_ONE + 16'd3, 1'b0);
        send_unit(16'h0039, 1'b0);
        send_unit(UNIT_ONE, 1'b0);
        send_unit(16'h2812, 1'b0);
        send_unit(UNIT_ONE + 16'd1, 1'b1);
        send_unit(UNIT_ONE + 16'd6, 1'b0);
        send_unit(16'h27FF, 1'b1);
        send_unit(16'h2900, 1'b1);
        send_unit(16'h0000, 1'b0);
        send_unit(UNIT_DASH, 1'b1);
        send_unit(16'hFFFF, 1'b1);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        send_unit(UNIT_ONE + 16'd5, 1'b0);
        send_unit(16'h002F, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1) ? 62 : (phase == 3) ? 17 : 0;
            stall_pct     = (phase == 2) ? 62 : (phase == 3) ? 17 : 0;
            run_lines(UNITS_PER_PHASE);
            wait_drained();
        end

        // Long output hold while input keeps coming, so the result queue backs up.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests++;
        run_lines(60);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d lines (%0d units) and checked %0d results,",
                 sb.lines_closed, sb.units_used, sb.cells_checked);
        $display("with idle and stall mixes on both sides and one long output hold.");
        if (sb.mismatches == 0 && sb.cells_due.size() == 0) begin
            $display("braille_dot_digits_to_cells_top verification clean");
        end else begin
            $display("braille_dot_digits_to_cells_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
